@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl of the list engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising clock edge outside reset
`define ICL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ICL_ASSERT_IMPL(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |-> (prop)) else $error(msg);

`endif

@@ rtl/core/icl_pkg.sv @@
// types and codes of the indexed circular list engine
package icl_pkg;

  localparam int NodeW = 8;

  typedef logic [NodeW-1:0] node_t;

  typedef enum logic [2:0] {
    OP_MAKE_ROOT  = 3'd0,
    OP_INS_AFTER  = 3'd1,
    OP_INS_BEFORE = 3'd2,
    OP_UNLINK     = 3'd3,
    OP_LOCATE     = 3'd4,
    OP_COUNT      = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EDIT1,
    ST_EDIT2,
    ST_WALK
  } state_e;

  // one port pair of a link memory: a write and a registered read
  typedef struct packed {
    logic  we;
    node_t waddr;
    node_t wdata;
    node_t raddr;
  } mem_req_t;

endpackage

@@ rtl/core/icl_ram.sv @@
// generic single write port ram with registered read
module icl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/icl_seq.sv @@
// command sequencer: link edits, ring walks and the clearing pass
module icl_seq #(
  parameter int NODES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        op_i,
  input  icl_pkg::node_t    ref_node_i,
  input  icl_pkg::node_t    item_node_i,
  output logic              result_valid_o,
  output icl_pkg::node_t    result_value_o,
  output icl_pkg::mem_req_t fwd_req_o,
  output icl_pkg::mem_req_t bwd_req_o,
  output icl_pkg::mem_req_t root_req_o,
  input  icl_pkg::node_t    fwd_rd_i,
  input  icl_pkg::node_t    bwd_rd_i,
  input  icl_pkg::node_t    root_rd_i
);

  localparam int DEPTH   = (NODES < 256) ? NODES : 256;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = $clog2(NODES);
  localparam int CW      = (SW > 8) ? SW : 8;
  localparam int CNT_CAP = (NODES - 1 < 255) ? NODES - 1 : 255;

  icl_pkg::state_e state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            result_valid_q, result_valid_d;
  icl_pkg::node_t  result_value_q, result_value_d;
  logic [2:0]      op_q, op_d;
  icl_pkg::node_t  ref_q, ref_d;
  icl_pkg::node_t  item_q, item_d;
  icl_pkg::node_t  a_q, a_d;
  icl_pkg::node_t  b_q, b_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  logic cmd_ok;
  logic walk_op;
  logic hit_root;
  logic hit_item;
  logic walk_end;
  logic edit_last;

  function automatic logic in_pool(icl_pkg::node_t n);
    in_pool = (32'(n) < 32'(NODES));
  endfunction

  always_comb begin
    unique case (op_i)
      icl_pkg::OP_MAKE_ROOT,
      icl_pkg::OP_UNLINK:    cmd_ok = in_pool(item_node_i);
      icl_pkg::OP_INS_AFTER,
      icl_pkg::OP_INS_BEFORE: cmd_ok = in_pool(item_node_i) && in_pool(ref_node_i);
      icl_pkg::OP_LOCATE,
      icl_pkg::OP_COUNT:     cmd_ok = in_pool(ref_node_i);
      default:               cmd_ok = 1'b0;
    endcase
  end

  // shared compare unit: the read link against the root and the item
  assign hit_root = (fwd_rd_i == ref_q);
  assign hit_item = (fwd_rd_i == item_q);
  assign walk_op  = (op_q == icl_pkg::OP_LOCATE) || (op_q == icl_pkg::OP_COUNT);

  always_comb begin
    if (op_q == icl_pkg::OP_LOCATE) begin
      walk_end = hit_root || hit_item || (cnt_q == CW'(NODES - 1));
    end else begin
      walk_end = hit_root || (cnt_q == CW'(CNT_CAP));
    end
  end

  // make root ends after its writes in EDIT1, unlinking a lone node writes nothing
  assign edit_last = (op_q == icl_pkg::OP_MAKE_ROOT) ||
                     ((op_q == icl_pkg::OP_UNLINK) && hit_item);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      icl_pkg::ST_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) state_d = icl_pkg::ST_IDLE;
      end
      icl_pkg::ST_IDLE: begin
        if (start_i && cmd_ok) state_d = icl_pkg::ST_READ;
      end
      icl_pkg::ST_READ: begin
        state_d = walk_op ? icl_pkg::ST_WALK : icl_pkg::ST_EDIT1;
      end
      icl_pkg::ST_EDIT1: begin
        state_d = edit_last ? icl_pkg::ST_IDLE : icl_pkg::ST_EDIT2;
      end
      icl_pkg::ST_EDIT2: begin
        state_d = icl_pkg::ST_IDLE;
      end
      icl_pkg::ST_WALK: begin
        if (walk_end) state_d = icl_pkg::ST_IDLE;
      end
      default: begin
        state_d = icl_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and memory requests
  always_comb begin
    fwd_req_o      = '{we: 1'b0, waddr: ref_q, wdata: item_q, raddr: ref_q};
    bwd_req_o      = '{we: 1'b0, waddr: ref_q, wdata: item_q, raddr: ref_q};
    root_req_o     = '{we: 1'b0, waddr: item_q, wdata: item_q, raddr: ref_q};
    busy_o         = (state_q != icl_pkg::ST_IDLE);
    clr_d          = clr_q;
    result_valid_d = 1'b0;
    result_value_d = result_value_q;
    op_d           = op_q;
    ref_d          = ref_q;
    item_d         = item_q;
    a_d            = a_q;
    b_d            = b_q;
    cnt_d          = cnt_q;

    unique case (state_q)
      icl_pkg::ST_CLEAR: begin
        fwd_req_o  = '{we: 1'b1, waddr: 8'(clr_q), wdata: 8'(clr_q), raddr: ref_q};
        bwd_req_o  = '{we: 1'b1, waddr: 8'(clr_q), wdata: 8'(clr_q), raddr: ref_q};
        root_req_o = '{we: 1'b1, waddr: 8'(clr_q), wdata: 8'(clr_q), raddr: ref_q};
        clr_d      = clr_q + AW'(1);
      end
      icl_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d   = op_i;
          ref_d  = ref_node_i;
          item_d = item_node_i;
          if (!cmd_ok) begin
            result_valid_d = 1'b1;
            result_value_d = '0;
          end
        end
      end
      icl_pkg::ST_READ: begin
        if (op_q == icl_pkg::OP_UNLINK) begin
          fwd_req_o.raddr = item_q;
          bwd_req_o.raddr = item_q;
        end
        cnt_d = '0;
      end
      icl_pkg::ST_EDIT1: begin
        a_d = fwd_rd_i;
        b_d = bwd_rd_i;
        unique case (op_q)
          icl_pkg::OP_INS_AFTER: begin
            fwd_req_o.we     = 1'b1;
            fwd_req_o.waddr  = ref_q;
            fwd_req_o.wdata  = item_q;
            bwd_req_o.we     = 1'b1;
            bwd_req_o.waddr  = item_q;
            bwd_req_o.wdata  = ref_q;
            root_req_o.we    = 1'b1;
            root_req_o.wdata = root_rd_i;
          end
          icl_pkg::OP_INS_BEFORE: begin
            bwd_req_o.we     = 1'b1;
            bwd_req_o.waddr  = ref_q;
            bwd_req_o.wdata  = item_q;
            fwd_req_o.we     = 1'b1;
            fwd_req_o.waddr  = item_q;
            fwd_req_o.wdata  = ref_q;
            root_req_o.we    = 1'b1;
            root_req_o.wdata = root_rd_i;
          end
          icl_pkg::OP_MAKE_ROOT,
          icl_pkg::OP_UNLINK: begin
            // item becomes a lone self-linked root
            if (!(op_q == icl_pkg::OP_UNLINK && hit_item)) begin
              fwd_req_o.we    = 1'b1;
              fwd_req_o.waddr = item_q;
              fwd_req_o.wdata = item_q;
              bwd_req_o.we    = 1'b1;
              bwd_req_o.waddr = item_q;
              bwd_req_o.wdata = item_q;
              root_req_o.we   = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (edit_last) begin
          result_valid_d = 1'b1;
          result_value_d = '0;
        end
      end
      icl_pkg::ST_EDIT2: begin
        unique case (op_q)
          icl_pkg::OP_INS_AFTER: begin
            fwd_req_o.we    = 1'b1;
            fwd_req_o.waddr = item_q;
            fwd_req_o.wdata = a_q;
            bwd_req_o.we    = 1'b1;
            bwd_req_o.waddr = a_q;
            bwd_req_o.wdata = item_q;
          end
          icl_pkg::OP_INS_BEFORE: begin
            bwd_req_o.we    = 1'b1;
            bwd_req_o.waddr = item_q;
            bwd_req_o.wdata = b_q;
            fwd_req_o.we    = 1'b1;
            fwd_req_o.waddr = b_q;
            fwd_req_o.wdata = item_q;
          end
          icl_pkg::OP_UNLINK: begin
            // join the former neighbors
            fwd_req_o.we    = 1'b1;
            fwd_req_o.waddr = b_q;
            fwd_req_o.wdata = a_q;
            bwd_req_o.we    = 1'b1;
            bwd_req_o.waddr = a_q;
            bwd_req_o.wdata = b_q;
          end
          default: begin
          end
        endcase
        result_valid_d = 1'b1;
        result_value_d = '0;
      end
      icl_pkg::ST_WALK: begin
        fwd_req_o.raddr = fwd_rd_i;
        if (walk_end) begin
          result_valid_d = 1'b1;
          if (op_q == icl_pkg::OP_COUNT) begin
            result_value_d = cnt_q[7:0];
          end else if (hit_root || hit_item) begin
            result_value_d = fwd_rd_i;
          end else begin
            result_value_d = ref_q;
          end
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= icl_pkg::ST_CLEAR;
      clr_q          <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_value_q <= result_value_d;
    op_q           <= op_d;
    ref_q          <= ref_d;
    item_q         <= item_d;
    a_q            <= a_d;
    b_q            <= b_d;
    cnt_q          <= cnt_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_value_o = result_value_q;

endmodule

@@ rtl/core/indexed_circular_list_engine.sv @@
// top level of the indexed circular list engine
//
// A pool of nodes, each with a forward link, a backward link and a root index,
// forming circular doubly linked rings held in three link memories.
// Command channel: op_i, ref_node_i and item_node_i transfer at a rising edge
// with start high and busy low. busy stays high while a command runs.
// Result channel: result_value_o is valid for exactly one cycle with
// result_valid_o high, and the receiver has no way to hold it off.
// Control states from the command transfer to the result strobe:
//   command with a node outside the pool or an unused op code: answered from IDLE
//   make root, or unlink of a lone node: READ, EDIT1
//   insert after, insert before, unlink: READ, EDIT1, EDIT2
//   locate and count: READ, then WALK until the stop, passing fewer than NODES nodes
// Every cycle is one registered read of a link memory, so a walk moves one
// node per cycle; busy is low in the cycle that shows the result, so the next
// command may transfer there.
// After reset a clearing pass makes every node a lone self-linked root,
// writing one entry per cycle, for all min(NODES, 256) entries, with busy high.
module indexed_circular_list_engine #(
  parameter int NODES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           op_i,
  input  logic [7:0]           ref_node_i,
  input  logic [7:0]           item_node_i,
  output logic                 result_valid_o,
  output logic [7:0]           result_value_o
);

  `include "assert_macros.svh"

  localparam int DEPTH = (NODES < 256) ? NODES : 256;
  localparam int AW    = $clog2(DEPTH);

  icl_pkg::mem_req_t fwd_req;
  icl_pkg::mem_req_t bwd_req;
  icl_pkg::mem_req_t root_req;
  icl_pkg::node_t    fwd_rd;
  icl_pkg::node_t    bwd_rd;
  icl_pkg::node_t    root_rd;

  icl_seq #(
    .NODES (NODES)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .op_i           (op_i),
    .ref_node_i     (ref_node_i),
    .item_node_i    (item_node_i),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o),
    .fwd_req_o      (fwd_req),
    .bwd_req_o      (bwd_req),
    .root_req_o     (root_req),
    .fwd_rd_i       (fwd_rd),
    .bwd_rd_i       (bwd_rd),
    .root_rd_i      (root_rd)
  );

  icl_ram #(
    .WIDTH (icl_pkg::NodeW),
    .DEPTH (DEPTH)
  ) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_req.we),
    .waddr_i (fwd_req.waddr[AW-1:0]),
    .wdata_i (fwd_req.wdata),
    .raddr_i (fwd_req.raddr[AW-1:0]),
    .rdata_o (fwd_rd)
  );

  icl_ram #(
    .WIDTH (icl_pkg::NodeW),
    .DEPTH (DEPTH)
  ) u_bwd_ram (
    .clk_i   (clk_i),
    .we_i    (bwd_req.we),
    .waddr_i (bwd_req.waddr[AW-1:0]),
    .wdata_i (bwd_req.wdata),
    .raddr_i (bwd_req.raddr[AW-1:0]),
    .rdata_o (bwd_rd)
  );

  icl_ram #(
    .WIDTH (icl_pkg::NodeW),
    .DEPTH (DEPTH)
  ) u_root_ram (
    .clk_i   (clk_i),
    .we_i    (root_req.we),
    .waddr_i (root_req.waddr[AW-1:0]),
    .wdata_i (root_req.wdata),
    .raddr_i (root_req.raddr[AW-1:0]),
    .rdata_o (root_rd)
  );

  `ICL_ASSERT_IMPL(a_result_when_idle, result_valid_o, !busy,
    "result strobe while a command is still running")
  `ICL_ASSERT_IMPL(a_start_answered, start && !busy, ##1 (busy || result_valid_o),
    "accepted command neither runs nor answers")
  `ICL_ASSERT(a_writes_while_busy, !(fwd_req.we || bwd_req.we || root_req.we) || busy,
    "link memory written while idle")

endmodule
